// ===== hw/rtl/sbsd_pkg.sv =====
// Shared types, constants and helpers for the block-scaled sample decoder.
// Used by the front decoder, the item queue, the emphasis back end and the top level.
package sbsd_pkg;

  localparam int NUM_SAMPLES = 4;
  localparam int SAMPLE_W    = 16;
  localparam int CODE_W      = 7;
  localparam int RAW_SHIFT   = 9;
  localparam int SCALE_W     = 4;
  localparam int ACC_W       = 32;
  localparam int EMPH_ROUND  = 32'h20;
  localparam int EMPH_SHIFT  = 16 - 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam sample_t SAT_MIN = sample_t'(-32768);
  localparam sample_t SAT_MAX = sample_t'(32767);

  // One decoded word waiting for the emphasis filter.
  typedef struct packed {
    sample_t [NUM_SAMPLES-1:0] raw;
    logic                      restart;
  } qitem_t;

  // Clamp a 31-bit value (accumulator shifted right by one) to 16 bits.
  function automatic sample_t saturate16(input logic signed [ACC_W-2:0] x);
    logic in_range;
    in_range = (x[ACC_W-2:SAMPLE_W-1] == {(ACC_W-SAMPLE_W){1'b0}}) ||
               (x[ACC_W-2:SAMPLE_W-1] == {(ACC_W-SAMPLE_W){1'b1}});
    if (in_range) begin
      return x[SAMPLE_W-1:0];
    end else if (x[ACC_W-2]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

// ===== hw/rtl/sbsd_front.sv =====
// Front end: takes compressed words from the input stream and expands the four codes.
// Depends on sbsd_pkg; pushes decoded items into sbsd_queue.
module sbsd_front
  import sbsd_pkg::*;
(
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block_word[31:0]
  input  logic        s_tuser,   // restart
  output logic        push,
  output qitem_t      item,
  input  logic        q_ready
);

  logic [CODE_W-1:0]  code [NUM_SAMPLES];
  logic [SCALE_W-1:0] scale;

  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready;
  assign scale    = s_tdata[7:4];

  always_comb begin
    code[0] = s_tdata[14:8];
    code[1] = s_tdata[22:16];
    code[2] = s_tdata[30:24];
    // The fourth code is spread over the spare top bits and the low nibble.
    code[3] = {s_tdata[15], s_tdata[23], s_tdata[31], s_tdata[3:0]};
  end

  always_comb begin
    item.restart = s_tuser;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      item.raw[i] = sample_t'(signed'({code[i], {RAW_SHIFT{1'b0}}}) >>> scale);
    end
  end

endmodule

// ===== hw/rtl/sbsd_queue.sv =====
// Short register queue that decouples the decoder from the emphasis filter.
// Depends on sbsd_pkg for the queued item type.
module sbsd_queue
  import sbsd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  output logic   in_ready,
  input  logic   pop,
  output qitem_t head,
  output logic   out_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qitem_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign out_valid = (count != '0);
  assign in_ready  = (count != CNT_W'(DEPTH));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/sbsd_back.sv =====
// Back end: runs the emphasis recurrence over the four raw values and holds the result.
// Depends on sbsd_pkg; drains sbsd_queue and drives the output stream register.
module sbsd_back
  import sbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  qitem_t      head,
  input  logic        q_valid,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  // previous_sample[15:0], sample_zero[31:16], sample_one[47:32],
  // sample_two[63:48], sample_three[79:64]
  output logic [79:0] m_tdata
);

  acc_t                       acc;
  sample_t                    last_sample;
  acc_t                       acc_next;
  sample_t [NUM_SAMPLES-1:0]  filt;

  // The output register takes a new result whenever it is empty or being drained.
  assign pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    acc_t a;
    acc_t leak;
    a = head.restart ? '0 : acc;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      leak    = (a + acc_t'(EMPH_ROUND)) >>> EMPH_SHIFT;
      a       = a + acc_t'(head.raw[i]) - leak;
      filt[i] = saturate16(a[ACC_W-1:1]);
    end
    acc_next = a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      last_sample <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (pop) begin
        acc         <= acc_next;
        last_sample <= filt[NUM_SAMPLES-1];
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {filt[3], filt[2], filt[1], filt[0], last_sample};
    end
  end

endmodule

// ===== hw/rtl/scaled_block_sample_decoder_emphasis_top.sv =====
// Top level of the block-scaled sample decoder with emphasis filter.
// Depends on sbsd_pkg, sbsd_front, sbsd_queue and sbsd_back.

// Each accepted 32-bit word yields one result of five 16-bit samples: the last
// sample of the word before and the four new filtered samples. The block takes one
// word per cycle while the queue has room; each word is written into the queue and
// its result then into the output register. The decoder feeds a queue of QUEUE_DEPTH words,
// so the input keeps flowing for that many words while the output is stalled. The
// four chained add steps of the emphasis filter form one combinational path ahead of the output
// register, and that path sets the clock. Restart clears only the filter
// accumulator; the previous-sample field still reports the last sample delivered.
module scaled_block_sample_decoder_emphasis_top
  import sbsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block_word[31:0]
  input  logic        s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  // previous_sample[15:0], sample_zero[31:16], sample_one[47:32],
  // sample_two[63:48], sample_three[79:64]
  output logic [79:0] m_tdata
);

  logic   push;
  logic   q_ready;
  logic   q_valid;
  logic   pop;
  qitem_t push_item;
  qitem_t head;

  sbsd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .item     (push_item),
    .q_ready  (q_ready)
  );

  sbsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .in_ready  (q_ready),
    .pop       (pop),
    .head      (head),
    .out_valid (q_valid)
  );

  sbsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_valid  (q_valid),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A full queue is never empty.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> q_valid)
    else $error("input stalled while the queue holds nothing");

  // A stalled output must not drain the queue.
  assert property (@(posedge clk) disable iff (rst)
      (q_valid && m_tvalid && !m_tready) |=> q_valid)
    else $error("queue lost an item while the output was stalled");

  // The next result reports the last sample of the result just taken.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tready) |=>
      (!m_tvalid || (m_tdata[15:0] == $past(m_tdata[79:64]))))
    else $error("previous sample does not match the last delivered sample");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_tvalid)
    else $error("output valid directly after reset");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the block-scaled sample decoder with emphasis filter.
// Depends on sbsd_pkg and scaled_block_sample_decoder_emphasis_top; predicts every result itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  // One result as it appears on m_tdata, previous sample in the lowest bits.
  typedef struct packed {
    sample_t three;
    sample_t two;
    sample_t one;
    sample_t zero;
    sample_t prev;
  } samples_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  // Filter state of the prediction, advanced once per accepted word.
  acc_t     emph_acc = '0;
  sample_t  last_sample = '0;
  samples_t expected_samples[$];

  scaled_block_sample_decoder_emphasis_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic acc_t expand_code(input logic [6:0] code, input logic [3:0] scale);
    acc_t v;
    v = {{25{code[6]}}, code};
    v = v <<< 9;
    return v >>> scale;
  endfunction

  function automatic sample_t clamp_half(input acc_t acc);
    acc_t h;
    h = acc >>> 1;
    if (h > SAT_MAX) begin
      return SAT_MAX;
    end else if (h < SAT_MIN) begin
      return SAT_MIN;
    end
    return sample_t'(h);
  endfunction

  function automatic samples_t decode_word(input logic [31:0] w, input logic restart);
    logic [6:0] codes [4];
    sample_t    filtered [4];
    acc_t       leak;
    samples_t   r;
    codes[0] = w[14:8];
    codes[1] = w[22:16];
    codes[2] = w[30:24];
    // The fourth code is scattered over the spare top bits and the low nibble.
    codes[3] = {w[15], w[23], w[31], w[3:0]};
    if (restart) begin
      emph_acc = '0;
    end
    r.prev = last_sample;
    for (int i = 0; i < 4; i++) begin
      leak = (emph_acc + EMPH_ROUND) >>> EMPH_SHIFT;
      emph_acc = emph_acc + expand_code(codes[i], w[7:4]) - leak;
      filtered[i] = clamp_half(emph_acc);
    end
    r.zero = filtered[0];
    r.one = filtered[1];
    r.two = filtered[2];
    r.three = filtered[3];
    last_sample = filtered[3];
    return r;
  endfunction

  function automatic logic [31:0] pack_codes(input logic [6:0] c0, input logic [6:0] c1,
                                             input logic [6:0] c2, input logic [6:0] c3,
                                             input logic [3:0] scale);
    return {c3[4], c2, c3[5], c1, c3[6], c0, scale, c3[3:0]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", result_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input sample_t got, input sample_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Sends one word; valid stays high after acceptance so back-to-back requests flow.
  task automatic send_word(input logic [31:0] w, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_samples.push_back(decode_word(w, restart));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_samples.size() != 0);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    samples_t got;
    samples_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_samples.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_samples.pop_front();
        check_field("previous_sample", got.prev, want.prev);
        check_field("sample_zero", got.zero, want.zero);
        check_field("sample_one", got.one, want.one);
        check_field("sample_two", got.two, want.two);
        check_field("sample_three", got.three, want.three);
      end
      result_count++;
    end
  end

  task automatic test_extremes();
    send_word(32'h0000_0000, 1'b0);
    send_word(pack_codes(7'h3f, 7'h3f, 7'h3f, 7'h3f, 4'd0), 1'b0);
    send_word(pack_codes(7'h40, 7'h40, 7'h40, 7'h40, 4'd0), 1'b0);
    send_word(pack_codes(7'h40, 7'h3f, 7'h7f, 7'h01, 4'd15), 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(pack_codes(7'h3f, 7'h40, 7'h3f, 7'h40, 4'd8), 1'b0);
    send_word(32'h0000_0000, 1'b0);
  endtask

  // Steady full-scale input pushes the accumulator well past the 16-bit range.
  task automatic test_saturation();
    for (int i = 0; i < 5; i++) begin
      send_word(pack_codes(7'h3f, 7'h3f, 7'h3f, 7'h3f, 4'd0), 1'b0);
    end
    for (int i = 0; i < 5; i++) begin
      send_word(pack_codes(7'h40, 7'h40, 7'h40, 7'h40, 4'd0), 1'b0);
    end
  endtask

  // Restart clears the accumulator but the previous sample must survive it.
  task automatic test_restart();
    send_word(pack_codes(7'h3f, 7'h3f, 7'h3f, 7'h3f, 4'd0), 1'b0);
    wait_for_drain();
    send_word(32'h0000_0000, 1'b1);
    send_word(pack_codes(7'h40, 7'h40, 7'h40, 7'h40, 4'd2), 1'b0);
    send_word(32'hffff_ffff, 1'b1);
    send_word(pack_codes(7'h15, 7'h6a, 7'h33, 7'h4c, 4'd5), 1'b1);
  endtask

  task automatic test_random(input int count);
    logic [31:0] w;
    logic [6:0]  c;
    int          kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        w = $urandom;
      end else if (kind < 90) begin
        // Runs of one code at a small scale drive the filter toward its limits.
        c = $urandom_range(1) ? 7'h3f : 7'h40;
        w = pack_codes(c, c, c, c, 4'($urandom_range(3)));
      end else if (kind < 95) begin
        w = 32'h0000_0000;
      end else begin
        w = 32'hffff_ffff;
      end
      send_word(w, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 47;
    test_extremes();
    test_saturation();
    test_restart();
    test_random(165);
    send_idle_pct = 47;
    recv_idle_pct = 23;
    test_random(165);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(170);
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
